### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Invariant, checked at every edge.
`define ASSERT_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) \
    else $error("assertion failed: invariant");

`endif

### hw/rtl/lifexc_pkg.sv
package lifexc_pkg;

  localparam int VOLT_W  = 24;
  localparam int SCALE_W = 16;
  localparam int REFR_W  = 16;
  localparam int INDEX_W = 10;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 17;

  localparam int DRIVE_W = VOLT_W + 3;
  localparam int MPROD_W = DRIVE_W + SCALE_W + 1;
  localparam int SPROD_W = VOLT_W + SCALE_W + 1;

  typedef logic signed [VOLT_W-1:0] volt_t;
  typedef logic [SCALE_W-1:0]       scale_t;
  typedef logic [REFR_W-1:0]        refr_t;
  typedef logic [INDEX_W-1:0]       index_t;

  localparam volt_t  REST_RESET   = 24'shC40000;
  localparam volt_t  THRESH_RESET = 24'shCE0000;
  localparam scale_t MSCALE_RESET = 16'd328;
  localparam scale_t SDECAY_RESET = 16'd64238;
  localparam refr_t  REFR_RESET   = 16'd50;

  localparam logic signed [31:0] V_MAX = 32'sd8388607;
  localparam logic signed [31:0] V_MIN = -32'sd8388608;

  typedef enum logic [1:0] {
    CMD_STEP    = 2'd0,
    CMD_ADD_SYN = 2'd1,
    CMD_SET_BG  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_REST   = 3'd0,
    REG_THRESH = 3'd1,
    REG_MSCALE = 3'd2,
    REG_SDECAY = 3'd3,
    REG_REFR   = 3'd4
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRIVE,
    ST_MUL,
    ST_WB
  } state_e;

  typedef struct packed {
    volt_t membrane;
    refr_t refr;
    volt_t syn;
    volt_t bg;
  } neuron_t;

  typedef struct packed {
    volt_t  rest;
    volt_t  thresh;
    scale_t mscale;
    scale_t sdecay;
    refr_t  refr_steps;
  } cfg_t;

  typedef struct packed {
    logic drive_en;
    logic mul_en;
  } alu_ctl_t;

  function automatic volt_t sat_volt(input logic signed [31:0] v);
    volt_t r;
    if (v > V_MAX) begin
      r = volt_t'(V_MAX);
    end else if (v < V_MIN) begin
      r = volt_t'(V_MIN);
    end else begin
      r = volt_t'(v);
    end
    return r;
  endfunction

endpackage

### hw/rtl/lifexc_cmd_if.sv
interface lifexc_cmd_if;
  logic                  valid;
  logic                  ready;
  lifexc_pkg::cmd_e      command;
  lifexc_pkg::index_t    neuron_index;
  lifexc_pkg::volt_t     operand_value;

  modport source (output valid, command, neuron_index, operand_value, input ready);
  modport sink   (input valid, command, neuron_index, operand_value, output ready);
endinterface

### hw/rtl/lifexc_res_if.sv
interface lifexc_res_if;
  logic               valid;
  logic               ready;
  lifexc_pkg::index_t result_index;
  logic               spiked;
  lifexc_pkg::volt_t  membrane_now;

  modport source (output valid, result_index, spiked, membrane_now, input ready);
  modport sink   (input valid, result_index, spiked, membrane_now, output ready);
endinterface

### hw/rtl/lifexc_alu.sv
module lifexc_alu (
  input  logic                 clk_i,
  input  lifexc_pkg::alu_ctl_t ctl_i,
  input  lifexc_pkg::cfg_t     cfg_i,
  input  lifexc_pkg::cmd_e     cmd_i,
  input  lifexc_pkg::volt_t    operand_i,
  input  lifexc_pkg::neuron_t  word_i,
  output lifexc_pkg::neuron_t  word_o,
  output logic                 spiked_o
);

  logic signed [lifexc_pkg::DRIVE_W-1:0] drive_d, drive_q;
  logic signed [lifexc_pkg::MPROD_W-1:0] mprod_q, mrnd;
  logic signed [lifexc_pkg::SPROD_W-1:0] sprod_q, sadj;
  logic signed [lifexc_pkg::MPROD_W-17:0] delta;
  logic signed [lifexc_pkg::SPROD_W-17:0] sdec;
  lifexc_pkg::volt_t stepped;

  assign drive_d = lifexc_pkg::DRIVE_W'(cfg_i.rest) - lifexc_pkg::DRIVE_W'(word_i.membrane)
                 + lifexc_pkg::DRIVE_W'(word_i.bg) + lifexc_pkg::DRIVE_W'(word_i.syn);

  always_ff @(posedge clk_i) begin
    if (ctl_i.drive_en) begin
      drive_q <= drive_d;
      sprod_q <= word_i.syn * $signed({1'b0, cfg_i.sdecay});
    end
    if (ctl_i.mul_en) begin
      mprod_q <= drive_q * $signed({1'b0, cfg_i.mscale});
    end
  end

  always_comb begin
    mrnd    = mprod_q + lifexc_pkg::MPROD_W'(32768);
    delta   = mrnd[lifexc_pkg::MPROD_W-1:16];
    sadj    = sprod_q + (sprod_q[lifexc_pkg::SPROD_W-1] ? lifexc_pkg::SPROD_W'(65535)
                                                       : lifexc_pkg::SPROD_W'(0));
    sdec    = sadj[lifexc_pkg::SPROD_W-1:16];
    stepped = lifexc_pkg::sat_volt(32'(word_i.membrane) + 32'(delta));

    word_o   = word_i;
    spiked_o = 1'b0;
    case (cmd_i)
      lifexc_pkg::CMD_STEP: begin
        if (word_i.refr == '0) begin
          if (stepped > cfg_i.thresh) begin
            spiked_o        = 1'b1;
            word_o.membrane = cfg_i.rest;
            word_o.refr     = cfg_i.refr_steps;
          end else begin
            word_o.membrane = stepped;
          end
        end else begin
          word_o.refr     = word_i.refr - lifexc_pkg::REFR_W'(1);
          word_o.membrane = cfg_i.rest;
        end
        word_o.syn = lifexc_pkg::sat_volt(32'(sdec));
      end
      lifexc_pkg::CMD_ADD_SYN: begin
        word_o.syn = lifexc_pkg::sat_volt(32'(word_i.syn) + 32'(operand_i));
      end
      lifexc_pkg::CMD_SET_BG: begin
        word_o.bg = operand_i;
      end
      default: begin
        word_o = word_i;
      end
    endcase
  end

endmodule

### hw/rtl/lif_neuron_exp_current_update.sv
// Array of leaky integrate-and-fire neurons with decaying synaptic current.
// cmd_i carries one beat per item (step, add synaptic input, set background
// current or no-op) for one neuron; res_o returns one beat per item with
// the neuron index, the spike flag and the membrane voltage after the item.
// The APB port sets rest, threshold, membrane scale, synaptic decay and the
// refractory length; write it only while no item is in flight.
// Each item goes through accept, reading the state word from the state
// memory, forming the drive, multiplying by the membrane scale and write-back;
// the result beat is registered at write-back. One item is in flight at a
// time, so the memory write lands before the next read.
// After reset the block sweeps every neuron of the state memory, one neuron
// per cycle, with cmd_i.ready low; APB writes are taken meanwhile.
// A finished result waits in the output register while the next item is
// accepted; if res_o stays stalled, write-back holds until the beat is taken.
module lif_neuron_exp_current_update #(
  parameter int NEURON_COUNT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lifexc_cmd_if.sink                          cmd_i,
  lifexc_res_if.source                        res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lifexc_pkg::ADDR_W-1:0]       paddr,
  input  logic [lifexc_pkg::DATA_W-1:0]       pwdata,
  output logic [lifexc_pkg::DATA_W-1:0]       prdata,
  output logic                                pready
);

  localparam int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NEURON_COUNT - 1);

  lifexc_pkg::state_e   state_q, state_d;
  lifexc_pkg::cfg_t     cfg_q;
  lifexc_pkg::neuron_t  store_q [NEURON_COUNT];
  lifexc_pkg::neuron_t  rdata_q, wb_word, mem_wdata;
  lifexc_pkg::cmd_e     cmd_q;
  lifexc_pkg::index_t   idx_q;
  lifexc_pkg::volt_t    op_q;
  lifexc_pkg::alu_ctl_t alu_ctl;
  logic [AW-1:0]        addr_q, clr_addr_q, mem_waddr;
  logic                 in_range_q, accept, wb_go, wb_fire, mem_we, wb_spiked;
  logic                 out_valid_q, out_spk_q;
  lifexc_pkg::index_t   out_idx_q;
  lifexc_pkg::volt_t    out_mem_q;

  assign accept  = cmd_i.valid && cmd_i.ready;
  assign wb_go   = !out_valid_q || res_o.ready;
  assign wb_fire = (state_q == lifexc_pkg::ST_WB) && wb_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest       <= lifexc_pkg::REST_RESET;
      cfg_q.thresh     <= lifexc_pkg::THRESH_RESET;
      cfg_q.mscale     <= lifexc_pkg::MSCALE_RESET;
      cfg_q.sdecay     <= lifexc_pkg::SDECAY_RESET;
      cfg_q.refr_steps <= lifexc_pkg::REFR_RESET;
    end else if (psel && penable && pwrite) begin
      case (lifexc_pkg::reg_e'(paddr[4:2]))
        lifexc_pkg::REG_REST:   cfg_q.rest       <= lifexc_pkg::volt_t'(pwdata[23:0]);
        lifexc_pkg::REG_THRESH: cfg_q.thresh     <= lifexc_pkg::volt_t'(pwdata[23:0]);
        lifexc_pkg::REG_MSCALE: cfg_q.mscale     <= pwdata[15:0];
        lifexc_pkg::REG_SDECAY: cfg_q.sdecay     <= pwdata[15:0];
        lifexc_pkg::REG_REFR:   cfg_q.refr_steps <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    case (lifexc_pkg::reg_e'(paddr[4:2]))
      lifexc_pkg::REG_REST:   prdata = {8'd0, cfg_q.rest};
      lifexc_pkg::REG_THRESH: prdata = {8'd0, cfg_q.thresh};
      lifexc_pkg::REG_MSCALE: prdata = {16'd0, cfg_q.mscale};
      lifexc_pkg::REG_SDECAY: prdata = {16'd0, cfg_q.sdecay};
      lifexc_pkg::REG_REFR:   prdata = {16'd0, cfg_q.refr_steps};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lifexc_pkg::ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == lifexc_pkg::ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lifexc_pkg::ST_CLEAR: if (clr_addr_q == LAST_ADDR) state_d = lifexc_pkg::ST_IDLE;
      lifexc_pkg::ST_IDLE:  if (accept) state_d = lifexc_pkg::ST_READ;
      lifexc_pkg::ST_READ:  state_d = lifexc_pkg::ST_DRIVE;
      lifexc_pkg::ST_DRIVE: state_d = lifexc_pkg::ST_MUL;
      lifexc_pkg::ST_MUL:   state_d = lifexc_pkg::ST_WB;
      lifexc_pkg::ST_WB:    if (wb_go) state_d = lifexc_pkg::ST_IDLE;
      default:              state_d = lifexc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_i.ready      = 1'b0;
    alu_ctl.drive_en = 1'b0;
    alu_ctl.mul_en   = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = addr_q;
    mem_wdata        = wb_word;
    case (state_q)
      lifexc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '{membrane: lifexc_pkg::REST_RESET, refr: '0, syn: '0, bg: '0};
      end
      lifexc_pkg::ST_IDLE:  cmd_i.ready = 1'b1;
      lifexc_pkg::ST_DRIVE: alu_ctl.drive_en = 1'b1;
      lifexc_pkg::ST_MUL:   alu_ctl.mul_en = 1'b1;
      lifexc_pkg::ST_WB:    mem_we = wb_go && in_range_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i.command;
      idx_q      <= cmd_i.neuron_index;
      op_q       <= cmd_i.operand_value;
      addr_q     <= AW'(cmd_i.neuron_index);
      in_range_q <= lifexc_pkg::COUNT_W'(cmd_i.neuron_index)
                    < lifexc_pkg::COUNT_W'(NEURON_COUNT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == lifexc_pkg::ST_READ) begin
      rdata_q <= store_q[addr_q];
    end
  end

  lifexc_alu u_alu (
    .clk_i     (clk_i),
    .ctl_i     (alu_ctl),
    .cfg_i     (cfg_q),
    .cmd_i     (cmd_q),
    .operand_i (op_q),
    .word_i    (rdata_q),
    .word_o    (wb_word),
    .spiked_o  (wb_spiked)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      out_idx_q <= idx_q;
      out_spk_q <= wb_spiked && in_range_q;
      out_mem_q <= in_range_q ? wb_word.membrane : '0;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.result_index = out_idx_q;
  assign res_o.spiked       = out_spk_q;
  assign res_o.membrane_now = out_mem_q;

endmodule

### hw/rtl/lifexc_checker.sv
`include "assert_macros.svh"

module lifexc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input lifexc_pkg::index_t       out_index_i,
  input logic                     out_spiked_i,
  input lifexc_pkg::volt_t        out_membrane_i,
  input logic                     pready_i
);

  logic in_beat, out_stall;

  assign in_beat   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // hold a stalled result beat
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall,
               out_valid_i && $stable(out_index_i) && $stable(out_spiked_i)
               && $stable(out_membrane_i))

  // drop ready after an accepted beat, one item in flight
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_beat, !in_ready_i)

  // no result may appear the cycle after an accept
  `ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_beat && !out_valid_i, !out_valid_i)

  `ASSERT_ALWAYS(a_pready_high, clk_i, pready_i)

endmodule

bind lif_neuron_exp_current_update lifexc_checker u_lifexc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (cmd_i.valid),
  .in_ready_i     (cmd_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_index_i    (res_o.result_index),
  .out_spiked_i   (res_o.spiked),
  .out_membrane_i (res_o.membrane_now),
  .pready_i       (pready)
);
